// File: src/qmu_pkg.sv
// qmu_pkg: shared constants, request/response codes and the allocation map command
// for the queued mutex unit. No dependencies.
`default_nettype none

package qmu_pkg;

  localparam int MUTEX_SLOTS_DEF = 64;
  localparam int QUEUE_DEPTH_DEF = 64;

  localparam int SLOT_W   = 6;
  localparam int THREAD_W = 10;
  localparam int ROW_W    = 32;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_DEALLOC = 2'd1,
    ACT_LOCK    = 2'd2,
    ACT_UNLOCK  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_REFUSED = 2'd2
  } status_t;

  // command from the sequencer to the in-use map
  typedef struct packed {
    logic clear;
    logic start;
    logic alloc;
    logic commit;
    logic slot_ok;
  } map_cmd_t;

endpackage

`default_nettype wire

// File: src/qmu_if.sv
// qmu_req_if / qmu_rsp_if: valid/ready channels for requests and responses.
// Depends on qmu_pkg.
`default_nettype none

interface qmu_req_if;
  logic                            valid;
  logic                            ready;
  qmu_pkg::action_t                action;
  logic [qmu_pkg::SLOT_W-1:0]      mutex_slot;
  logic [qmu_pkg::THREAD_W-1:0]    caller_thread;

  modport source (output valid, action, mutex_slot, caller_thread, input ready);
  modport sink (input valid, action, mutex_slot, caller_thread, output ready);
endinterface

interface qmu_rsp_if;
  logic                            valid;
  logic                            ready;
  qmu_pkg::status_t                status;
  logic [qmu_pkg::SLOT_W-1:0]      granted_slot;
  logic                            must_wait;
  logic                            wake_valid;
  logic [qmu_pkg::THREAD_W-1:0]    wake_thread;

  modport source (output valid, status, granted_slot, must_wait, wake_valid, wake_thread,
                  input ready);
  modport sink (input valid, status, granted_slot, must_wait, wake_valid, wake_thread,
                output ready);
endinterface

`default_nettype wire

// File: src/queued_mutex_unit.sv
// queued_mutex_unit: top level of the hardware mutex table with FIFO waiter rings.
// Depends on qmu_pkg, qmu_if, qmu_alloc_map, qmu_ring_mem and qmu_ctrl.
//
// A request is accepted only in the idle state. It then reads the head/count table, and an
// unlock of a non-empty ring needs one more read of the waiter ring. Both memories have a
// synchronous read, and one request is in work at a time. The response is loaded after the
// table read, or after the ring read for such an unlock. A response waits in its output
// register while the next request is accepted. That request is then held until the
// register is taken. After reset a clearing pass over all slot indexes zeroes the
// head/count table and the in-use rows. No request is accepted during it. Lock and unlock
// act on a slot's ring whether or not the slot is allocated.
`default_nettype none

module queued_mutex_unit #(
  parameter int MUTEX_SLOTS = qmu_pkg::MUTEX_SLOTS_DEF,
  parameter int QUEUE_DEPTH = qmu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  qmu_req_if.sink   req,
  qmu_rsp_if.source rsp
);

  localparam int SW         = (MUTEX_SLOTS > 1) ? $clog2(MUTEX_SLOTS) : 1;
  localparam int RING_DEPTH = MUTEX_SLOTS * QUEUE_DEPTH;
  localparam int RAW        = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  qmu_pkg::map_cmd_t            map_cmd;
  logic [SW-1:0]                map_slot;
  logic                         map_found;
  logic [SW-1:0]                map_grant;
  logic                         ring_wr_en;
  logic [RAW-1:0]               ring_wr_addr;
  logic [qmu_pkg::THREAD_W-1:0] ring_wr_data;
  logic                         ring_rd_en;
  logic [RAW-1:0]               ring_rd_addr_a;
  logic [RAW-1:0]               ring_rd_addr_b;
  logic [qmu_pkg::THREAD_W-1:0] ring_rd_data_a;
  logic [qmu_pkg::THREAD_W-1:0] ring_rd_data_b;

  qmu_alloc_map #(
    .MUTEX_SLOTS (MUTEX_SLOTS),
    .SW          (SW)
  ) u_alloc_map (
    .clk   (clk),
    .rst   (rst),
    .cmd   (map_cmd),
    .slot  (map_slot),
    .found (map_found),
    .grant (map_grant)
  );

  qmu_ring_mem #(
    .DEPTH (RING_DEPTH),
    .AW    (RAW)
  ) u_ring_mem (
    .clk       (clk),
    .wr_en     (ring_wr_en),
    .wr_addr   (ring_wr_addr),
    .wr_data   (ring_wr_data),
    .rd_en     (ring_rd_en),
    .rd_addr_a (ring_rd_addr_a),
    .rd_addr_b (ring_rd_addr_b),
    .rd_data_a (ring_rd_data_a),
    .rd_data_b (ring_rd_data_b)
  );

  qmu_ctrl #(
    .MUTEX_SLOTS (MUTEX_SLOTS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .SW          (SW),
    .RAW         (RAW)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .req            (req),
    .rsp            (rsp),
    .map_cmd        (map_cmd),
    .map_slot       (map_slot),
    .map_found      (map_found),
    .map_grant      (map_grant),
    .ring_wr_en     (ring_wr_en),
    .ring_wr_addr   (ring_wr_addr),
    .ring_wr_data   (ring_wr_data),
    .ring_rd_en     (ring_rd_en),
    .ring_rd_addr_a (ring_rd_addr_a),
    .ring_rd_addr_b (ring_rd_addr_b),
    .ring_rd_data_a (ring_rd_data_a),
    .ring_rd_data_b (ring_rd_data_b)
  );

endmodule

`default_nettype wire

// File: src/qmu_alloc_map.sv
// qmu_alloc_map: in-use bits of all mutex slots, kept in a row memory of 32-bit words,
// with a per-row full flag for the lowest-free-slot search. Depends on qmu_pkg.
`default_nettype none

module qmu_alloc_map #(
  parameter int MUTEX_SLOTS = qmu_pkg::MUTEX_SLOTS_DEF,
  parameter int SW          = (MUTEX_SLOTS > 1) ? $clog2(MUTEX_SLOTS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  qmu_pkg::map_cmd_t cmd,
  input  logic [SW-1:0]     slot,
  output logic              found,
  output logic [SW-1:0]     grant
);

  localparam int BW        = qmu_pkg::ROW_W;
  localparam int BS        = $clog2(BW);
  localparam int ROWS      = (MUTEX_SLOTS + BW - 1) / BW;
  localparam int RW        = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int XW        = SW + BS;
  localparam int LAST_BITS = MUTEX_SLOTS - BW * (ROWS - 1);
  localparam logic [BW-1:0] ONE      = 1;
  localparam logic [BW-1:0] LAST_PAD = ~((ONE << LAST_BITS) - ONE);

  logic [BW-1:0] row_mem [ROWS];
  logic [BW-1:0] rdata;
  logic [ROWS-1:0] row_full;

  logic [RW-1:0] row_q;
  logic [BS-1:0] bit_q;
  logic          alloc_q;
  logic          found_q;

  logic [XW-1:0] slot_x;
  logic [RW-1:0] slot_row;
  logic [RW-1:0] free_row;
  logic          free_any;
  logic [BW-1:0] pad;
  logic [BW-1:0] row_eff;
  logic [BS-1:0] zbit;
  logic [BW-1:0] set_row;
  logic [BW-1:0] clr_row;

  logic          wr_en;
  logic [RW-1:0] wr_addr;
  logic [BW-1:0] wr_data;

  assign slot_x   = XW'(slot);
  assign slot_row = RW'(slot_x >> BS);

  // lowest row that still has a free slot
  always_comb begin
    free_row = '0;
    free_any = 1'b0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (!row_full[r]) begin
        free_row = RW'(r);
        free_any = 1'b1;
      end
    end
  end

  // slots past the end of the table count as taken
  assign pad     = (row_q == RW'(ROWS - 1)) ? LAST_PAD : '0;
  assign row_eff = rdata | pad;

  always_comb begin
    zbit = '0;
    for (int b = BW - 1; b >= 0; b--) begin
      if (!row_eff[b]) begin
        zbit = BS'(b);
      end
    end
  end

  assign set_row = rdata | (ONE << zbit);
  assign clr_row = rdata & ~(ONE << bit_q);
  assign found   = found_q;
  assign grant   = SW'({row_q, zbit});

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = row_q;
    wr_data = set_row;
    if (cmd.clear) begin
      wr_en   = (int'(slot) < ROWS);
      wr_addr = RW'(slot);
      wr_data = '0;
    end else if (cmd.commit && alloc_q) begin
      wr_en = found_q;
    end else if (cmd.commit) begin
      wr_en   = cmd.slot_ok;
      wr_data = clr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rdata   <= row_mem[cmd.alloc ? free_row : slot_row];
      row_q   <= cmd.alloc ? free_row : slot_row;
      bit_q   <= slot_x[BS-1:0];
      alloc_q <= cmd.alloc;
      found_q <= cmd.alloc & free_any;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_full <= '0;
    end else if (cmd.commit && !cmd.clear) begin
      if (alloc_q && found_q) begin
        row_full[row_q] <= &(set_row | pad);
      end else if (!alloc_q && cmd.slot_ok) begin
        row_full[row_q] <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/qmu_ring_mem.sv
// qmu_ring_mem: waiter ring storage for all mutexes, one write port and two
// registered read ports. Depends on qmu_pkg.
`default_nettype none

module qmu_ring_mem #(
  parameter int DEPTH = qmu_pkg::MUTEX_SLOTS_DEF * qmu_pkg::QUEUE_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [qmu_pkg::THREAD_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr_a,
  input  logic [AW-1:0]                rd_addr_b,
  output logic [qmu_pkg::THREAD_W-1:0] rd_data_a,
  output logic [qmu_pkg::THREAD_W-1:0] rd_data_b
);

  logic [qmu_pkg::THREAD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

`default_nettype wire

// File: src/qmu_ctrl.sv
// qmu_ctrl: request sequencer with the per-mutex head/count table and the response
// register. Depends on qmu_pkg and the qmu_req_if/qmu_rsp_if channels.
`default_nettype none

module qmu_ctrl #(
  parameter int MUTEX_SLOTS = qmu_pkg::MUTEX_SLOTS_DEF,
  parameter int QUEUE_DEPTH = qmu_pkg::QUEUE_DEPTH_DEF,
  parameter int SW          = (MUTEX_SLOTS > 1) ? $clog2(MUTEX_SLOTS) : 1,
  parameter int RAW         = (MUTEX_SLOTS * QUEUE_DEPTH > 1) ?
                              $clog2(MUTEX_SLOTS * QUEUE_DEPTH) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  qmu_req_if.sink                      req,
  qmu_rsp_if.source                    rsp,
  output qmu_pkg::map_cmd_t            map_cmd,
  output logic [SW-1:0]                map_slot,
  input  logic                         map_found,
  input  logic [SW-1:0]                map_grant,
  output logic                         ring_wr_en,
  output logic [RAW-1:0]               ring_wr_addr,
  output logic [qmu_pkg::THREAD_W-1:0] ring_wr_data,
  output logic                         ring_rd_en,
  output logic [RAW-1:0]               ring_rd_addr_a,
  output logic [RAW-1:0]               ring_rd_addr_b,
  input  logic [qmu_pkg::THREAD_W-1:0] ring_rd_data_a,
  input  logic [qmu_pkg::THREAD_W-1:0] ring_rd_data_b
);

  localparam int HW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int SLW = qmu_pkg::SLOT_W;

  typedef struct packed {
    logic [HW-1:0] head;
    logic [CW-1:0] count;
  } meta_t;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_META  = 4'b0100,
    S_RING  = 4'b1000
  } state_t;

  state_t state, state_next;

  meta_t meta_mem [MUTEX_SLOTS];
  meta_t meta_rd;
  logic  meta_we;
  logic [SW-1:0] meta_wa;
  meta_t meta_wd;

  logic [SW-1:0]                clr_idx;
  qmu_pkg::action_t             action_q;
  logic [SW-1:0]                slot_q;
  logic                         slot_ok_q;
  logic [qmu_pkg::THREAD_W-1:0] caller_q;

  logic          acc;
  logic          fin;
  logic          lock_ok;
  logic          unlock_pre;
  logic          to_ring;
  logic          head_match;
  logic          load;
  logic [CW:0]   tail_sum;
  logic [HW-1:0] tail_pos;
  logic [HW-1:0] next_head;
  logic [RAW-1:0] ring_base;

  qmu_pkg::status_t             r_status;
  logic [SLW-1:0]               r_grant;
  logic                         r_wait;
  logic                         r_wake;
  logic [qmu_pkg::THREAD_W-1:0] r_thread;

  assign req.ready = (state == S_IDLE);
  assign acc       = req.valid && req.ready;
  assign fin       = !rsp.valid || rsp.ready;

  // request capture and table read
  always_ff @(posedge clk) begin
    if (acc) begin
      action_q  <= req.action;
      slot_q    <= SW'(req.mutex_slot);
      slot_ok_q <= (int'(req.mutex_slot) < MUTEX_SLOTS);
      caller_q  <= req.caller_thread;
      meta_rd   <= meta_mem[SW'(req.mutex_slot)];
    end
  end

  assign lock_ok    = slot_ok_q && (meta_rd.count < CW'(QUEUE_DEPTH));
  assign unlock_pre = slot_ok_q && (meta_rd.count != '0);
  assign to_ring    = (action_q == qmu_pkg::ACT_UNLOCK) && unlock_pre;
  assign head_match = (ring_rd_data_a == caller_q);

  // ring positions wrap with one compare and subtract
  assign tail_sum  = (CW + 1)'(meta_rd.head) + (CW + 1)'(meta_rd.count);
  assign tail_pos  = (tail_sum >= (CW + 1)'(QUEUE_DEPTH)) ?
                     HW'(tail_sum - (CW + 1)'(QUEUE_DEPTH)) : HW'(tail_sum);
  assign next_head = (meta_rd.head == HW'(QUEUE_DEPTH - 1)) ? '0 : meta_rd.head + 1'b1;
  assign ring_base = RAW'(slot_q) * RAW'(QUEUE_DEPTH);

  assign ring_wr_en     = (state == S_META) && fin &&
                          (action_q == qmu_pkg::ACT_LOCK) && lock_ok;
  assign ring_wr_addr   = ring_base + RAW'(tail_pos);
  assign ring_wr_data   = caller_q;
  assign ring_rd_en     = (state == S_META) && to_ring;
  assign ring_rd_addr_a = ring_base + RAW'(meta_rd.head);
  assign ring_rd_addr_b = ring_base + RAW'(next_head);

  assign map_cmd.clear   = (state == S_CLEAR);
  assign map_cmd.start   = acc;
  assign map_cmd.alloc   = (req.action == qmu_pkg::ACT_ALLOC);
  assign map_cmd.commit  = (state == S_META) && fin &&
                           ((action_q == qmu_pkg::ACT_ALLOC) ||
                            (action_q == qmu_pkg::ACT_DEALLOC));
  assign map_cmd.slot_ok = slot_ok_q;
  assign map_slot        = (state == S_CLEAR) ? clr_idx : SW'(req.mutex_slot);

  // head/count table write port
  always_comb begin
    meta_we = 1'b0;
    meta_wa = slot_q;
    meta_wd = '0;
    if (state == S_CLEAR) begin
      meta_we = 1'b1;
      meta_wa = clr_idx;
    end else if (state == S_META && fin) begin
      case (action_q)
        qmu_pkg::ACT_ALLOC: begin
          meta_we = map_found;
          meta_wa = map_grant;
        end
        qmu_pkg::ACT_LOCK: begin
          meta_we       = lock_ok;
          meta_wd.head  = meta_rd.head;
          meta_wd.count = meta_rd.count + 1'b1;
        end
        default: begin
          meta_we = 1'b0;
        end
      endcase
    end else if (state == S_RING && fin && head_match) begin
      meta_we       = 1'b1;
      meta_wd.head  = (meta_rd.count > CW'(1)) ? next_head : meta_rd.head;
      meta_wd.count = meta_rd.count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_wa] <= meta_wd;
    end
  end

  // response for the transaction in flight
  always_comb begin
    r_status = qmu_pkg::ST_OK;
    r_grant  = '0;
    r_wait   = 1'b0;
    r_wake   = 1'b0;
    r_thread = '0;
    if (state == S_RING) begin
      if (!head_match) begin
        r_status = qmu_pkg::ST_REFUSED;
      end else if (meta_rd.count > CW'(1)) begin
        r_wake   = 1'b1;
        r_thread = ring_rd_data_b;
      end
    end else begin
      case (action_q)
        qmu_pkg::ACT_ALLOC: begin
          if (map_found) begin
            r_grant = SLW'(map_grant);
          end else begin
            r_status = qmu_pkg::ST_FULL;
          end
        end
        qmu_pkg::ACT_DEALLOC: begin
          r_status = qmu_pkg::ST_OK;
        end
        qmu_pkg::ACT_LOCK: begin
          if (lock_ok) begin
            r_wait = (meta_rd.count != '0);
          end else begin
            r_status = qmu_pkg::ST_FULL;
          end
        end
        qmu_pkg::ACT_UNLOCK: begin
          // empty ring or bad slot, refused before the ring read
          r_status = qmu_pkg::ST_REFUSED;
        end
      endcase
    end
  end

  assign load = fin && (((state == S_META) && !to_ring) || (state == S_RING));

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_idx == SW'(MUTEX_SLOTS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (acc) state_next = S_META;
      end
      S_META: begin
        if (to_ring) state_next = S_RING;
        else if (fin) state_next = S_IDLE;
      end
      S_RING: begin
        if (fin) state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_idx <= clr_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.status       <= r_status;
      rsp.granted_slot <= r_grant;
      rsp.must_wait    <= r_wait;
      rsp.wake_valid   <= r_wake;
      rsp.wake_thread  <= r_thread;
    end
  end

endmodule

`default_nettype wire

// File: src/qmu_checker.sv
// qmu_checker: port-level checks of the queued mutex unit, bound to the top level.
// Depends on qmu_pkg and queued_mutex_unit.
`default_nettype none

module qmu_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input qmu_pkg::status_t             status,
  input logic [qmu_pkg::SLOT_W-1:0]   granted_slot,
  input logic                         must_wait,
  input logic                         wake_valid,
  input logic [qmu_pkg::THREAD_W-1:0] wake_thread
);

  // a held response keeps its contents
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(granted_slot) &&
      $stable(must_wait) && $stable(wake_valid) && $stable(wake_thread))
    else $error("response changed while stalled");

  // one request in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in work");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != qmu_pkg::ST_OK |->
      !must_wait && !wake_valid && granted_slot == '0 && wake_thread == '0)
    else $error("failed transaction carries result fields");

  a_wake_thread: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !wake_valid |-> wake_thread == '0)
    else $error("wake thread without wake");

  a_wait_or_wake: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(must_wait && wake_valid) &&
      (status == qmu_pkg::ST_OK || status == qmu_pkg::ST_FULL ||
       status == qmu_pkg::ST_REFUSED))
    else $error("inconsistent response");

endmodule

bind queued_mutex_unit qmu_checker u_qmu_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .status       (rsp.status),
  .granted_slot (rsp.granted_slot),
  .must_wait    (rsp.must_wait),
  .wake_valid   (rsp.wake_valid),
  .wake_thread  (rsp.wake_thread)
);

`default_nettype wire

// File: tb/sv/mutex_table_checker.sv
// mutex_table_checker: watches the request and response channels of queued_mutex_unit,
// predicts every response from its own copy of the mutex table and compares them in order.
// Depends on qmu_pkg and the qmu_req_if / qmu_rsp_if interfaces.
module mutex_table_checker (
  input  logic clk,
  input  logic rst,
  qmu_req_if   req_mon,
  qmu_rsp_if   rsp_mon,
  output int   fail_count,
  output int   pending,
  output int   checked,
  output int   wakes
);
  import qmu_pkg::*;

  localparam int SLOTS = MUTEX_SLOTS_DEF;
  localparam int DEPTH = QUEUE_DEPTH_DEF;

  typedef struct packed {
    status_t               status;
    logic [SLOT_W-1:0]     granted_slot;
    logic                  must_wait;
    logic                  wake_valid;
    logic [THREAD_W-1:0]   wake_thread;
  } mutex_rsp_t;

  bit                  slot_used [SLOTS];
  logic [THREAD_W-1:0] waiters [SLOTS][DEPTH];
  int unsigned         ring_start [SLOTS];
  int unsigned         ring_len [SLOTS];
  mutex_rsp_t          expected_rsp_q [$];

  // applies one request to the table copy and returns the response it must give
  function automatic mutex_rsp_t predict_response(action_t act, logic [SLOT_W-1:0] slot,
                                                  logic [THREAD_W-1:0] thread);
    mutex_rsp_t r;
    r = '0;
    r.status = ST_OK;
    case (act)
      ACT_ALLOC: begin
        r.status = ST_FULL;
        for (int i = 0; i < SLOTS; i++) begin
          if (!slot_used[i]) begin
            slot_used[i] = 1'b1;
            ring_start[i] = 0;
            ring_len[i] = 0;
            r.status = ST_OK;
            r.granted_slot = SLOT_W'(i);
            break;
          end
        end
      end
      ACT_DEALLOC: begin
        // ring contents survive, only the in-use bit drops
        if (int'(slot) < SLOTS) slot_used[slot] = 1'b0;
      end
      ACT_LOCK: begin
        if (int'(slot) >= SLOTS || ring_len[slot] >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          waiters[slot][(ring_start[slot] + ring_len[slot]) % DEPTH] = thread;
          r.must_wait = (ring_len[slot] > 0);
          ring_len[slot]++;
        end
      end
      ACT_UNLOCK: begin
        if (int'(slot) >= SLOTS || ring_len[slot] == 0 ||
            waiters[slot][ring_start[slot]] != thread) begin
          r.status = ST_REFUSED;
        end else begin
          // last holder leaving keeps the head where it is
          if (ring_len[slot] > 1) begin
            ring_start[slot] = (ring_start[slot] + 1) % DEPTH;
            r.wake_valid = 1'b1;
            r.wake_thread = waiters[slot][ring_start[slot]];
          end
          ring_len[slot]--;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    mutex_rsp_t want;
    mutex_rsp_t got;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_used[i] = 1'b0;
        ring_start[i] = 0;
        ring_len[i] = 0;
      end
      expected_rsp_q.delete();
    end else begin
      // a response can never belong to the request taken at the same edge
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.status = rsp_mon.status;
        got.granted_slot = rsp_mon.granted_slot;
        got.must_wait = rsp_mon.must_wait;
        got.wake_valid = rsp_mon.wake_valid;
        got.wake_thread = rsp_mon.wake_thread;
        if (expected_rsp_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 25)
            $display("%0t: unexpected response transaction status=%0d slot=%0d", $time,
                     got.status, got.granted_slot);
        end else begin
          want = expected_rsp_q.pop_front();
          checked++;
          if (got.wake_valid === 1'b1) wakes++;
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 25)
              $display("%0t: response mismatch: expected status=%0d slot=%0d ", $time,
                       want.status, want.granted_slot,
                       "wait=%0b wake=%0b thread=%0d, ", want.must_wait, want.wake_valid,
                       want.wake_thread,
                       "actual status=%0d slot=%0d wait=%0b wake=%0b thread=%0d",
                       got.status, got.granted_slot, got.must_wait, got.wake_valid,
                       got.wake_thread);
          end
        end
      end
      if (req_mon.valid && req_mon.ready)
        expected_rsp_q.push_back(predict_response(req_mon.action, req_mon.mutex_slot,
                                                  req_mon.caller_thread));
    end
    pending = expected_rsp_q.size();
  end

endmodule

// File: tb/sv/queued_mutex_unit_test.sv
// queued_mutex_unit_test: drives directed and random mutex requests into queued_mutex_unit
// with random idling on both channels; mutex_table_checker does the checking.
// Depends on qmu_pkg, qmu_req_if / qmu_rsp_if, queued_mutex_unit and mutex_table_checker.
module queued_mutex_unit_test;
  import qmu_pkg::*;

  localparam int SLOTS = MUTEX_SLOTS_DEF;
  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1250;

  logic clk = 1'b0;
  logic rst = 1'b1;

  qmu_req_if req ();
  qmu_rsp_if rsp ();

  int fail_count;
  int pending;
  int checked;
  int wakes;

  queued_mutex_unit u_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  mutex_table_checker u_chk (
    .clk(clk),
    .rst(rst),
    .req_mon(req),
    .rsp_mon(rsp),
    .fail_count(fail_count),
    .pending(pending),
    .checked(checked),
    .wakes(wakes)
  );

  always #6 clk = ~clk;

  // shadow of slot use and lock order, only to steer the stimulus toward real owners
  bit                  slot_taken [SLOTS];
  logic [THREAD_W-1:0] owner_q [SLOTS][$];
  logic [SLOT_W-1:0]   hot_slots [4];
  logic [THREAD_W-1:0] thread_pool [6];
  bit                  calm;
  int                  sent;
  int                  act_count [4];

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // called at a rising edge; returns at a rising edge with valid still high if no gap
  task automatic send_req(action_t act, logic [SLOT_W-1:0] slot, logic [THREAD_W-1:0] thread);
    int gap;
    req.valid <= 1'b1;
    req.action <= act;
    req.mutex_slot <= slot;
    req.caller_thread <= thread;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    case (act)
      ACT_ALLOC: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!slot_taken[i]) begin
            slot_taken[i] = 1'b1;
            owner_q[i].delete();
            break;
          end
        end
      end
      ACT_DEALLOC: slot_taken[slot] = 1'b0;
      ACT_LOCK: if (owner_q[slot].size() < DEPTH) owner_q[slot].push_back(thread);
      ACT_UNLOCK: begin
        if (owner_q[slot].size() > 0 && owner_q[slot][0] == thread)
          void'(owner_q[slot].pop_front());
      end
    endcase
    act_count[int'(act)]++;
    sent++;
    gap = gap_len();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_mixed();
    int r;
    logic [SLOT_W-1:0] slot;
    logic [THREAD_W-1:0] thread;
    r = $urandom_range(0, 99);
    slot = ($urandom_range(0, 9) < 7) ? hot_slots[$urandom_range(0, 3)] : SLOT_W'($urandom);
    thread = thread_pool[$urandom_range(0, 5)];
    if (r < 12) begin
      send_req(ACT_ALLOC, SLOT_W'($urandom), thread);
    end else if (r < 24) begin
      send_req(ACT_DEALLOC, slot, thread);
    end else if (r < 62) begin
      send_req(ACT_LOCK, slot, thread);
    end else begin
      // mostly the current owner, sometimes a thread that should be refused
      if (owner_q[slot].size() > 0 && $urandom_range(0, 4) != 0) thread = owner_q[slot][0];
      send_req(ACT_UNLOCK, slot, thread);
    end
  endtask

  // fill one ring past its depth, then hand the mutex down the whole line
  task automatic fill_ring(logic [SLOT_W-1:0] slot);
    int room;
    room = DEPTH - owner_q[slot].size();
    repeat (room + 1) send_req(ACT_LOCK, slot, THREAD_W'($urandom));
    while (owner_q[slot].size() > 0) send_req(ACT_UNLOCK, slot, owner_q[slot][0]);
    send_req(ACT_UNLOCK, slot, THREAD_W'($urandom));
  endtask

  task automatic exhaust_alloc();
    int free_n;
    free_n = 0;
    foreach (slot_taken[i]) if (!slot_taken[i]) free_n++;
    repeat (free_n + 2) send_req(ACT_ALLOC, SLOT_W'($urandom), THREAD_W'($urandom));
    repeat (10) send_req(ACT_DEALLOC, SLOT_W'($urandom), THREAD_W'($urandom));
  endtask

  // hold the request side until every response is back
  task automatic drain_pending();
    req.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin
    int off;
    rsp.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      rsp.ready <= 1'b1;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      off = gap_len();
      if (off > 0) begin
        rsp.ready <= 1'b0;
        repeat (off) @(posedge clk);
      end
    end
  end

  initial begin
    int phase;
    int directed_n;
    req.valid = 1'b0;
    req.action = ACT_ALLOC;
    req.mutex_slot = '0;
    req.caller_thread = '0;
    calm = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty ring, lock and unlock on a slot never allocated, order of ownership
    send_req(ACT_UNLOCK, 6'd0, 10'd0);
    send_req(ACT_LOCK, 6'd63, 10'd1023);
    send_req(ACT_LOCK, 6'd63, 10'd0);
    send_req(ACT_UNLOCK, 6'd63, 10'd0);
    send_req(ACT_UNLOCK, 6'd63, 10'd1023);
    send_req(ACT_UNLOCK, 6'd63, 10'd0);
    send_req(ACT_UNLOCK, 6'd63, 10'd0);
    // allocation order and deallocation of free slots
    send_req(ACT_ALLOC, 6'd63, 10'd1023);
    send_req(ACT_ALLOC, 6'd0, 10'd0);
    send_req(ACT_DEALLOC, 6'd0, 10'd0);
    send_req(ACT_DEALLOC, 6'd0, 10'd0);
    send_req(ACT_ALLOC, 6'd42, 10'd512);
    send_req(ACT_DEALLOC, 6'd5, 10'd5);
    // ring survives deallocate, wake goes to the next thread id
    send_req(ACT_LOCK, 6'd1, 10'h2aa);
    send_req(ACT_LOCK, 6'd1, 10'h155);
    send_req(ACT_DEALLOC, 6'd1, 10'd0);
    send_req(ACT_UNLOCK, 6'd1, 10'h2aa);
    send_req(ACT_UNLOCK, 6'd1, 10'h155);
    send_req(ACT_ALLOC, 6'd21, 10'd21);
    drain_pending();
    directed_n = sent;

    for (phase = 0; sent - directed_n < RANDOM_ITEMS; phase++) begin
      foreach (hot_slots[i]) hot_slots[i] = SLOT_W'($urandom);
      foreach (thread_pool[i]) thread_pool[i] = THREAD_W'($urandom);
      calm = ($urandom_range(0, 3) == 0);
      case (phase % 6)
        1: fill_ring(hot_slots[0]);
        3: exhaust_alloc();
        default: repeat ($urandom_range(40, 120)) send_mixed();
      endcase
      if (phase % 4 == 2) drain_pending();
    end

    drain_pending();
    repeat (8) @(posedge clk);
    @(negedge clk);
    $display("run covered %0d requests: %0d allocate, %0d deallocate, %0d lock, %0d unlock",
             sent, act_count[int'(ACT_ALLOC)], act_count[int'(ACT_DEALLOC)],
             act_count[int'(ACT_LOCK)], act_count[int'(ACT_UNLOCK)]);
    $display("%0d responses checked, %0d of them handed the mutex to a waiter", checked, wakes);
    if (fail_count == 0) begin
      $display("[queued_mutex_unit] OK");
    end else begin
      $display("[queued_mutex_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #18000000;
    $display("timeout with %0d responses outstanding", pending);
    $display("[queued_mutex_unit] ERROR");
    $finish;
  end

endmodule
